/* sv/bithin_pkg.sv */
// Shared types and constants for the binary image thinning block.
// No dependencies; imported by every module of the block.
package bithin_pkg;

  localparam int DEF_MAX_ROWS = 240;
  localparam int DEF_MAX_COLS = 320;

  // wide enough for any clamped dimension up to 1024
  localparam int DIM_W = 11;

  localparam logic [7:0] PIX_FG = 8'd255;
  localparam logic [7:0] PIX_BG = 8'd0;
  localparam logic [7:0] ITER_MAX = 8'd255;

  localparam logic [1:0] OP_WRITE     = 2'd0;
  localparam logic [1:0] OP_WRITE_END = 2'd1;
  localparam logic [1:0] OP_READ      = 2'd2;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] pixel;
  } cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

/* sv/bithin_front.sv */
// Front end: accepts input words, classifies them into commands and queues them.
// Depends on bithin_pkg.
module bithin_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic [7:0]          in_pixel_in,
  input  logic                in_frame_end_in,
  output bithin_pkg::head_t   head,
  input  logic                pop
);
  import bithin_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cmd_in;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;

  always_comb begin
    if (in_req_type) begin
      cmd_in.op = OP_READ;
    end else if (in_frame_end_in) begin
      cmd_in.op = OP_WRITE_END;
    end else begin
      cmd_in.op = OP_WRITE;
    end
    cmd_in.pixel = in_pixel_in;
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.cmd   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

/* sv/bithin_back.sv */
// Back end: frame memories (two banks), pixel write/read, thinning sequencer and
// result register. Depends on bithin_pkg.
module bithin_back #(
  parameter int MAX_ROWS = bithin_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = bithin_pkg::DEF_MAX_COLS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bithin_pkg::head_t head,
  output logic              pop,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [8:0]        cfg_wdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_result_kind,
  output logic [7:0]        out_pixel_out,
  output logic              out_frame_end_out,
  output logic [7:0]        out_iteration_count
);
  import bithin_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PTR_W  = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_T_RD  = 3'd2;
  localparam logic [2:0] S_T_CAP = 3'd3;
  localparam logic [2:0] S_T_WR  = 3'd4;
  localparam logic [2:0] S_REP   = 3'd5;

  logic [7:0] mem0 [DEPTH];
  logic [7:0] mem1 [DEPTH];
  logic [7:0] rd0_r, rd1_r, rdata;

  logic [2:0]       state_r, state_nxt;
  logic [7:0]       rows_cfg_r;
  logic [8:0]       cols_cfg_r;
  logic [DIM_W-1:0] rows_u, cols_u;
  logic [PTR_W-1:0] total_r;
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt, rp_eff;
  logic             cur_r, cur_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [DIM_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [3:0]       k_r, k_nxt, k_last;
  logic             cap_v_r;
  logic [3:0]       cap_k_r;
  logic [7:0]       win_r [9];
  logic             sub_r, sub_nxt, del_r, del_nxt;
  logic [7:0]       passes_r, passes_nxt;
  logic             rd_fe_r, rd_fe_nxt;
  logic             border;

  logic              out_valid_r, out_kind_r, out_fe_r;
  logic [7:0]        out_pix_r, out_iter_r;

  logic [ADDR_W-1:0] raddr, waddr, colsa, rowbase, nbaddr;
  logic [7:0]        wdata;
  logic              we0, we1, pix_we, thin_we, issue;

  logic [7:0] nb [8];
  logic [3:0] nz_cnt;
  logic [3:0] trans;
  logic       cond_a, cond_b, kill;
  logic [7:0] new_pix;

  // dimension clamp
  always_comb begin
    logic [DIM_W-1:0] rw, cw;
    rw = DIM_W'(rows_cfg_r);
    cw = DIM_W'(cols_cfg_r);
    if (rw < DIM_W'(3)) begin
      rows_u = DIM_W'(3);
    end else if (rw > DIM_W'(MAX_ROWS)) begin
      rows_u = DIM_W'(MAX_ROWS);
    end else begin
      rows_u = rw;
    end
    if (cw < DIM_W'(3)) begin
      cols_u = DIM_W'(3);
    end else if (cw > DIM_W'(MAX_COLS)) begin
      cols_u = DIM_W'(MAX_COLS);
    end else begin
      cols_u = cw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= 8'd240;
      cols_cfg_r <= 9'd320;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS: rows_cfg_r <= cfg_wdata[7:0];
        CFG_COLS: cols_cfg_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    total_r <= PTR_W'(rows_u) * PTR_W'(cols_u);
  end

  assign border = (row_r == '0) || (row_r == rows_u - DIM_W'(1)) ||
                  (col_r == '0) || (col_r == cols_u - DIM_W'(1));
  assign k_last = border ? 4'd0 : 4'd8;
  assign rp_eff = (rp_r >= total_r) ? '0 : rp_r;
  assign rdata  = cur_r ? rd1_r : rd0_r;

  // neighbor address: slot 0 center, 1..8 clockwise from north
  assign colsa = ADDR_W'(cols_u);
  always_comb begin
    priority case (k_r)
      4'd1, 4'd2, 4'd8: rowbase = pos_r - colsa;
      4'd4, 4'd5, 4'd6: rowbase = pos_r + colsa;
      default:          rowbase = pos_r;
    endcase
    priority case (k_r)
      4'd2, 4'd3, 4'd4: nbaddr = rowbase + ADDR_W'(1);
      4'd6, 4'd7, 4'd8: nbaddr = rowbase - ADDR_W'(1);
      default:          nbaddr = rowbase;
    endcase
  end

  // Zhang-Suen decision on the captured window
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      nb[j] = win_r[j + 1];
    end
    nz_cnt = '0;
    trans  = '0;
    for (int j = 0; j < 8; j++) begin
      nz_cnt = nz_cnt + {3'd0, (nb[j] != PIX_BG)};
      trans  = trans + {3'd0, (nb[j] == PIX_BG) && (nb[(j + 1) % 8] == PIX_FG)};
    end
    if (!sub_r) begin
      cond_a = (nb[0] == PIX_BG) || (nb[2] == PIX_BG) || (nb[4] == PIX_BG);
      cond_b = (nb[2] == PIX_BG) || (nb[4] == PIX_BG) || (nb[6] == PIX_BG);
    end else begin
      cond_a = (nb[0] == PIX_BG) || (nb[2] == PIX_BG) || (nb[6] == PIX_BG);
      cond_b = (nb[0] == PIX_BG) || (nb[4] == PIX_BG) || (nb[6] == PIX_BG);
    end
    kill = !border && (win_r[0] == PIX_FG) && (nz_cnt >= 4'd2) && (nz_cnt <= 4'd6) &&
           (trans == 4'd1) && cond_a && cond_b;
    if (border) begin
      new_pix = win_r[0];
    end else if ((win_r[0] == PIX_FG) && !kill) begin
      new_pix = PIX_FG;
    end else begin
      new_pix = PIX_BG;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    cur_nxt    = cur_r;
    pos_nxt    = pos_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    k_nxt      = k_r;
    sub_nxt    = sub_r;
    del_nxt    = del_r;
    passes_nxt = passes_r;
    rd_fe_nxt  = rd_fe_r;
    pop        = 1'b0;
    pix_we     = 1'b0;
    thin_we    = 1'b0;
    issue      = 1'b0;
    raddr      = nbaddr;
    unique case (state_r)
      S_IDLE: begin
        raddr = rp_eff[ADDR_W-1:0];
        if (head.valid) begin
          if (head.cmd.op == OP_READ) begin
            if (!out_valid_r) begin
              pop       = 1'b1;
              rd_fe_nxt = (rp_eff + PTR_W'(1) == total_r);
              rp_nxt    = rd_fe_nxt ? '0 : rp_eff + PTR_W'(1);
              state_nxt = S_RD;
            end
          end else begin
            pop = 1'b1;
            if (wp_r < total_r) begin
              pix_we = 1'b1;
              wp_nxt = wp_r + PTR_W'(1);
            end
            if (head.cmd.op == OP_WRITE_END) begin
              pos_nxt    = '0;
              row_nxt    = '0;
              col_nxt    = '0;
              k_nxt      = '0;
              sub_nxt    = 1'b0;
              del_nxt    = 1'b0;
              passes_nxt = '0;
              state_nxt  = S_T_RD;
            end
          end
        end
      end
      S_RD: state_nxt = S_IDLE;
      S_T_RD: begin
        issue = 1'b1;
        if (k_r == k_last) begin
          k_nxt     = '0;
          state_nxt = S_T_CAP;
        end else begin
          k_nxt = k_r + 4'd1;
        end
      end
      S_T_CAP: state_nxt = S_T_WR;
      S_T_WR: begin
        thin_we   = 1'b1;
        del_nxt   = del_r | kill;
        state_nxt = S_T_RD;
        if ((row_r == rows_u - DIM_W'(1)) && (col_r == cols_u - DIM_W'(1))) begin
          cur_nxt = ~cur_r;
          pos_nxt = '0;
          row_nxt = '0;
          col_nxt = '0;
          if (!sub_r) begin
            sub_nxt = 1'b1;
          end else begin
            sub_nxt    = 1'b0;
            del_nxt    = 1'b0;
            passes_nxt = (passes_r == ITER_MAX) ? ITER_MAX : passes_r + 8'd1;
            if (!(del_r | kill)) begin
              state_nxt = S_REP;
            end
          end
        end else begin
          pos_nxt = pos_r + ADDR_W'(1);
          if (col_r == cols_u - DIM_W'(1)) begin
            col_nxt = '0;
            row_nxt = row_r + DIM_W'(1);
          end else begin
            col_nxt = col_r + DIM_W'(1);
          end
        end
      end
      S_REP: begin
        if (!out_valid_r) begin
          wp_nxt    = '0;
          rp_nxt    = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // pixel writes land in the live bank, thinning writes in the other one
  assign waddr = pix_we ? wp_r[ADDR_W-1:0] : pos_r;
  assign wdata = pix_we ? head.cmd.pixel : new_pix;
  assign we0   = (pix_we && !cur_r) || (thin_we && cur_r);
  assign we1   = (pix_we && cur_r) || (thin_we && !cur_r);

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[waddr] <= wdata;
    end
    rd0_r <= mem0[raddr];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[waddr] <= wdata;
    end
    rd1_r <= mem1[raddr];
  end

  always_ff @(posedge clk) begin
    cap_k_r <= k_r;
    if (cap_v_r) begin
      win_r[cap_k_r] <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      cur_r       <= 1'b0;
      pos_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      k_r         <= '0;
      sub_r       <= 1'b0;
      del_r       <= 1'b0;
      passes_r    <= '0;
      rd_fe_r     <= 1'b0;
      cap_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      cur_r    <= cur_nxt;
      pos_r    <= pos_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      k_r      <= k_nxt;
      sub_r    <= sub_nxt;
      del_r    <= del_nxt;
      passes_r <= passes_nxt;
      rd_fe_r  <= rd_fe_nxt;
      cap_v_r  <= issue;
      if ((state_r == S_RD) || ((state_r == S_REP) && !out_valid_r)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RD) begin
      out_kind_r <= KIND_PIXEL;
      out_pix_r  <= rdata;
      out_fe_r   <= rd_fe_r;
      out_iter_r <= '0;
    end else if ((state_r == S_REP) && !out_valid_r) begin
      out_kind_r <= KIND_REPORT;
      out_pix_r  <= PIX_BG;
      out_fe_r   <= 1'b0;
      out_iter_r <= passes_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_kind_r;
  assign out_pixel_out       = out_pix_r;
  assign out_frame_end_out   = out_fe_r;
  assign out_iteration_count = out_iter_r;

endmodule

/* sv/binary_image_thinning.sv */
// Top level of the binary image thinning block: front queue plus back end.
// Depends on bithin_pkg, bithin_front and bithin_back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  in       | in_valid / in_ready    | in_req_type, in_pixel_in, in_frame_end_in
//  out      | out_valid / out_ready  | out_result_kind, out_pixel_out,
//           |                        | out_frame_end_out, out_iteration_count
//  cfg      | cfg_we                 | cfg_index, cfg_wdata
//
// Pixel writes retire one per cycle while the back end is idle. A read word passes
// through the memory read register and the S_RD state before it is valid; back to
// back reads do not overlap, as the next read waits for the output register to drain.
// Thinning visits every pixel once per subiteration, two subiterations per iteration,
// in the states S_T_RD, S_T_CAP and S_T_WR, reading the window through the single read
// port of the frame memory (centre only at a border); input stalls (queue full) meanwhile.
// Reset is synchronous, active low; memories are not cleared.
module binary_image_thinning #(
  parameter int MAX_ROWS = bithin_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = bithin_pkg::DEF_MAX_COLS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [7:0] in_pixel_in,
  input  logic       in_frame_end_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_result_kind,
  output logic [7:0] out_pixel_out,
  output logic       out_frame_end_out,
  output logic [7:0] out_iteration_count,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_wdata
);
  import bithin_pkg::*;

  head_t head;
  logic  pop;

  bithin_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_pixel_in     (in_pixel_in),
    .in_frame_end_in (in_frame_end_in),
    .head            (head),
    .pop             (pop)
  );

  bithin_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (head),
    .pop                 (pop),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_pixel_out       (out_pixel_out),
    .out_frame_end_out   (out_frame_end_out),
    .out_iteration_count (out_iteration_count)
  );

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid) else $error("pop from empty queue");

  a_report_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_REPORT) |->
      (out_pixel_out == PIX_BG && !out_frame_end_out)) else $error("bad report word");

  a_pixel_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_PIXEL) |-> (out_iteration_count == 8'd0))
    else $error("pixel word carries count");

endmodule
